FILE: sv/double_ended_queue_macros.svh
// Assertion macros used by the double-ended queue datapath.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DEQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define DEQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/deq_pkg.sv
// Package with the types and codes of the double-ended queue.
package deq_pkg;

  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_DUMP_ELEM  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DUMP_EMPTY = 3'd4;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DUMP_READ,
    ST_DUMP_EMIT
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                put_front;
    logic                put_back;
    logic                take_front;
    logic                take_back;
    logic                load_status;
    logic [STATUS_W-1:0] status;
    logic                dump_start;
    logic                dump_read;
    logic                dump_emit;
  } deq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic last;
    logic out_free;
  } deq_stat_t;

endpackage

FILE: sv/deq_req_if.sv
// Request channel of the double-ended queue.
interface deq_req_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

FILE: sv/deq_rsp_if.sv
// Result channel of the double-ended queue.
interface deq_rsp_if import deq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] word;
  logic                     final_res;

  modport source (output valid, status, word, final_res, input ready);
  modport sink   (input valid, status, word, final_res, output ready);
endinterface

FILE: sv/double_ended_queue.sv
// Top level of the double-ended queue.
//
//   channel  modport  payload                      role
//   req      sink     kind[2:0], value[31:0]       push, pop or dump request
//   rsp      source   status[2:0], word[31:0],     zero or more results per request
//                     final_res
//
// A push or pop is taken whenever the result register is free.
// A dump holds off requests, stalls included, until its last entry is out: it is taken,
// then each entry gets a registered read of the single ring read port and a result load.
// A stall on rsp holds the result register and stops new requests.
// Reset empties the queue and refuses requests; the ring store is not cleared.
module double_ended_queue import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input logic    clk,
  input logic    rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_cmd_t  cmd;
  deq_stat_t stat;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0]   out_word;
  logic                out_final;
  logic                out_valid;

  // Controller.
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // Datapath.
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (req.value),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (rsp.ready),
    .out_status (out_status),
    .out_word   (out_word),
    .out_final  (out_final)
  );

  // Result channel.
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.word      = out_word;
  assign rsp.final_res = out_final;

endmodule

FILE: sv/deq_ctrl.sv
// Controller state machine of the double-ended queue.
module deq_ctrl import deq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [KIND_W-1:0] req_kind,
  input  deq_stat_t         stat,
  output logic              req_ready,
  output deq_cmd_t          cmd
);

  deq_state_t state;
  deq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = stat.out_free;
        if (req_valid && stat.out_free) begin
          case (req_kind)
            KIND_PUSH_FRONT: begin
              cmd.load_status = 1'b1;
              if (stat.full) begin
                cmd.status = STATUS_FULL;
              end else begin
                cmd.status    = STATUS_OK;
                cmd.put_front = 1'b1;
              end
            end
            KIND_PUSH_BACK: begin
              cmd.load_status = 1'b1;
              if (stat.full) begin
                cmd.status = STATUS_FULL;
              end else begin
                cmd.status   = STATUS_OK;
                cmd.put_back = 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              cmd.load_status = 1'b1;
              if (stat.empty) begin
                cmd.status = STATUS_EMPTY;
              end else begin
                cmd.status     = STATUS_OK;
                cmd.take_front = 1'b1;
              end
            end
            KIND_POP_BACK: begin
              cmd.load_status = 1'b1;
              if (stat.empty) begin
                cmd.status = STATUS_EMPTY;
              end else begin
                cmd.status    = STATUS_OK;
                cmd.take_back = 1'b1;
              end
            end
            KIND_DUMP: begin
              if (stat.empty) begin
                cmd.load_status = 1'b1;
                cmd.status      = STATUS_DUMP_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_next     = ST_DUMP_READ;
              end
            end
            default: begin
              // Unused kinds are taken and dropped without a result.
            end
          endcase
        end
      end
      ST_DUMP_READ: begin
        cmd.dump_read = 1'b1;
        state_next    = ST_DUMP_EMIT;
      end
      ST_DUMP_EMIT: begin
        if (stat.out_free) begin
          cmd.dump_emit = 1'b1;
          state_next    = stat.last ? ST_IDLE : ST_DUMP_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/deq_datapath.sv
// Datapath of the double-ended queue: ring store, indices and result register.
module deq_datapath import deq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  deq_cmd_t            cmd,
  input  logic [WORD_W-1:0]   push_value,
  output deq_stat_t           stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [WORD_W-1:0]   out_word,
  output logic                out_final
);

  `include "double_ended_queue_macros.svh"

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] occ;
  logic [IDX_W-1:0] walk_ptr;
  logic [CNT_W-1:0] remaining;

  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [IDX_W-1:0] walk_dec;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] back_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] back_idx;

  // Ring index arithmetic; every sum stays below twice the depth while the queue is not empty.
  always_comb begin
    front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
    front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
    walk_dec  = (walk_ptr == '0) ? LAST_IDX : walk_ptr - 1'b1;
    tail_sum  = SUM_W'(front) + SUM_W'(occ);
    back_sum  = tail_sum - 1'b1;
    tail_idx  = (tail_sum >= DEPTH_S) ? IDX_W'(tail_sum - DEPTH_S) : IDX_W'(tail_sum);
    back_idx  = (back_sum >= DEPTH_S) ? IDX_W'(back_sum - DEPTH_S) : IDX_W'(back_sum);
  end

  // Status towards the controller; nothing is taken while in reset.
  always_comb begin
    stat.full     = (occ == DEPTH_C);
    stat.empty    = (occ == '0);
    stat.last     = (remaining == CNT_W'(1));
    stat.out_free = !rst && (!out_valid || out_ready);
  end

  // Ring store write port.
  always_ff @(posedge clk) begin
    if (cmd.put_front) begin
      mem[front_dec] <= push_value;
    end else if (cmd.put_back) begin
      mem[tail_idx] <= push_value;
    end
  end

  // Ring store read port, registered.
  always_ff @(posedge clk) begin
    if (cmd.dump_read) begin
      rd_data <= mem[walk_ptr];
    end
  end

  // Front index and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      occ   <= '0;
    end else begin
      if (cmd.put_front) begin
        front <= front_dec;
        occ   <= occ + 1'b1;
      end else if (cmd.put_back) begin
        occ <= occ + 1'b1;
      end else if (cmd.take_front) begin
        front <= front_inc;
        occ   <= occ - 1'b1;
      end else if (cmd.take_back) begin
        occ <= occ - 1'b1;
      end
    end
  end

  // Dump walker: starts at the back entry and steps towards the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.dump_start) begin
      remaining <= occ;
    end else if (cmd.dump_emit) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump_start) begin
      walk_ptr <= back_idx;
    end else if (cmd.dump_emit) begin
      walk_ptr <= walk_dec;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.dump_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_status <= cmd.status;
      out_word   <= '0;
      out_final  <= 1'b1;
    end else if (cmd.dump_emit) begin
      out_status <= STATUS_DUMP_ELEM;
      out_word   <= rd_data;
      out_final  <= stat.last;
    end
  end

  // Checks on the queue bookkeeping.
  `DEQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ <= DEPTH_C, "occupancy above depth")
  `DEQ_ASSERT_IMPL(a_front_bound, 1'b1, front <= LAST_IDX, "front index outside ring")
  `DEQ_ASSERT_IMPL(a_push_room, cmd.put_front || cmd.put_back, !stat.full,
                   "push commanded on a full queue")
  `DEQ_ASSERT_IMPL(a_load_free, cmd.load_status || cmd.dump_emit, stat.out_free,
                   "result register overwritten")
  `DEQ_ASSERT_NEXT(a_load_shows, cmd.load_status || cmd.dump_emit, out_valid,
                   "loaded result not presented")

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the double-ended queue, with a shadow deque as predictor.
`timescale 1ns / 1ps

module tb_top import deq_pkg::*; ();

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 4000;

  // Kinds above a dump are spare codes that the block must ignore.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_DUMP + 3'd1;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] word;
    logic                     final_res;
  } deq_result_t;

  logic clk;
  logic rst;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the queue contents.
  logic signed [WORD_W-1:0] shadow_slots [DEPTH];
  logic [5:0]               shadow_front;
  logic [6:0]               shadow_count;

  deq_result_t pending_results [$];
  int          fail_count;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void owe_result(logic [STATUS_W-1:0] status,
                                     logic signed [WORD_W-1:0] word, logic final_res);
    deq_result_t r;
    r.status    = status;
    r.word      = word;
    r.final_res = final_res;
    pending_results = {pending_results, r};
  endfunction

  // Applies one accepted request to the shadow deque and queues the results it owes.
  function automatic void apply_to_shadow_deque(logic [KIND_W-1:0] kind,
                                                logic signed [WORD_W-1:0] value);
    int n;
    int pos;
    n = shadow_count;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (n >= DEPTH) begin
          owe_result(STATUS_FULL, '0, 1'b1);
        end else begin
          shadow_front = (shadow_front == 0) ? 6'(DEPTH - 1) : shadow_front - 6'd1;
          shadow_slots[shadow_front] = value;
          shadow_count++;
          owe_result(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_PUSH_BACK: begin
        if (n >= DEPTH) begin
          owe_result(STATUS_FULL, '0, 1'b1);
        end else begin
          pos = (int'(shadow_front) + n) % DEPTH;
          shadow_slots[pos] = value;
          shadow_count++;
          owe_result(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_POP_FRONT: begin
        if (n == 0) begin
          owe_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          shadow_front = 6'((int'(shadow_front) + 1) % DEPTH);
          shadow_count--;
          owe_result(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_POP_BACK: begin
        if (n == 0) begin
          owe_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          shadow_count--;
          owe_result(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (n == 0) begin
          owe_result(STATUS_DUMP_EMPTY, '0, 1'b1);
        end else begin
          // Back entry first, front entry last and flagged.
          for (int k = 0; k < n; k++) begin
            pos = (int'(shadow_front) + n - 1 - k) % DEPTH;
            owe_result(STATUS_DUMP_ELEM, shadow_slots[pos], k == n - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Words are mostly random, with the signed extremes, zero and minus one mixed in.
  function automatic logic signed [WORD_W-1:0] random_word();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request, with random idle cycles first, and waits for it to be taken.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [WORD_W-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= kind;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_to_shadow_deque(kind, value);
  endtask

  task automatic send_push(input logic signed [WORD_W-1:0] value);
    send_request($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, value);
  endtask

  task automatic send_pop();
    send_request($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, random_word());
  endtask

  // Pops and dumps on an empty queue, and the spare kinds that give no result.
  task automatic test_empty_requests();
    send_request(KIND_POP_FRONT, 32'sh7FFF_FFFF);
    send_request(KIND_POP_BACK, '1);
    send_request(KIND_DUMP, 32'sh8000_0000);
    for (int s = 0; s < 3; s++) begin
      send_request(KIND_SPARE_LO + 3'(s), random_word());
    end
  endtask

  // Extreme words at both ends, a dump, then pops down to the sole entry and past it.
  task automatic test_directed_values();
    send_request(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    send_request(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_request(KIND_PUSH_BACK, '0);
    send_request(KIND_PUSH_FRONT, '1);
    send_request(KIND_PUSH_BACK, 32'sh5555_5555);
    send_request(KIND_PUSH_FRONT, 32'shAAAA_AAAA);
    send_request(KIND_DUMP, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_DUMP, '0);
    send_request(KIND_POP_FRONT, '0);
    send_request(KIND_DUMP, '0);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_PUSH_FRONT, 32'sd7);
    send_request(KIND_POP_BACK, '0);
    send_request(KIND_DUMP, '0);
  endtask

  // Fills the ring to capacity, pushes into a full queue, dumps it, drains it, then pops and dumps it empty.
  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH) send_push(random_word());
    send_request(KIND_PUSH_FRONT, random_word());
    send_request(KIND_PUSH_BACK, random_word());
    send_request(KIND_DUMP, random_word());
    while (shadow_count != 0) send_pop();
    send_pop();
    send_request(KIND_DUMP, random_word());
  endtask

  // Random mix with a slight lean towards pushes, so the queue depth wanders.
  task automatic test_random_traffic(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 42)      send_push(random_word());
      else if (pick < 80) send_pop();
      else if (pick < 93) send_request(KIND_DUMP, random_word());
      else                send_request(KIND_SPARE_LO + 3'($urandom_range(2)), random_word());
    end
  endtask

  // Receiver stalls at random and each result is checked against the oldest one owed.
  always @(posedge clk) begin : result_check
    deq_result_t want;
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d word %0d final_res %0d",
               rsp_ch.status, rsp_ch.word, rsp_ch.final_res);
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.word !== want.word) begin
          $error("word: expected %0d, actual %0d", want.word, rsp_ch.word);
          fail_count++;
        end
        if (rsp_ch.final_res !== want.final_res) begin
          $error("final_res: expected %0d, actual %0d", want.final_res, rsp_ch.final_res);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("double_ended_queue test failed");
    $finish;
  end

  initial begin
    req_ch.valid  = 1'b0;
    req_ch.kind   = KIND_PUSH_FRONT;
    req_ch.value  = '0;
    rsp_ch.ready  = 1'b0;
    rst           = 1'b1;
    shadow_front  = '0;
    shadow_count  = '0;
    fail_count    = 0;
    send_idle_pct = 28;
    recv_idle_pct = 83;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_requests();
    test_directed_values();
    test_random_traffic(120);

    send_idle_pct = 83;
    recv_idle_pct = 28;
    test_fill_and_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);
    req_ch.valid <= 1'b0;

    // Let the last dump finish, then watch for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 16) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/deq_pkg.sv
sv/deq_req_if.sv
sv/deq_rsp_if.sv
sv/deq_ctrl.sv
sv/deq_datapath.sv
sv/double_ended_queue.sv
dv/tb_top.sv
